/* hw/rtl/sdsv_pkg.sv */
// Package for the step/direction servo velocity loop.
// Widths, reset values, register indexes and shared structs; no dependencies.
package sdsv_pkg;

	localparam int ADC_BITS      = 10;
	localparam int COUNT_WIDTH   = 16;
	localparam int SAMPLE_OFFSET = 512;

	// stored sample = raw + offset
	localparam int SMP_W   = $clog2((1 << ADC_BITS) + SAMPLE_OFFSET);
	localparam int VEL_W   = 9;
	localparam int MAG_W   = VEL_W - 1;
	localparam int PER_W   = 8;
	localparam int LIM_W   = 8;
	localparam int SCALE_W = 6;
	localparam int BASE_W  = 14;
	localparam int SPU_W   = 8;
	localparam int TICK_W  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// counter minus sample, formed without wrap
	localparam int DIFF_W = ((COUNT_WIDTH > SMP_W + 1) ? COUNT_WIDTH : SMP_W + 1) + 1;
	localparam int PROD_W = SCALE_W + MAG_W;
	localparam int NUM_W  = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 1;
	localparam int PERIOD_SHIFT = 6;
	localparam int QUO_W  = NUM_W - 1 - PERIOD_SHIFT;

	localparam logic [PER_W-1:0]  PERIOD_MAX  = '1;
	localparam logic [LIM_W-1:0]  LIMIT_RST   = LIM_W'(255);
	localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(49);
	localparam logic [BASE_W-1:0] BASE_RST    = BASE_W'(16335);
	localparam logic [SPU_W-1:0]  SPU_RST     = SPU_W'(2);
	localparam logic [PER_W-1:0]  PERIOD_RST  = PER_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VEL_LIMIT  = 2'd0,
		REG_RATE_SCALE = 2'd1,
		REG_RATE_BASE  = 2'd2,
		REG_SAMPLES    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LIM_W-1:0]   limit;
		logic [SCALE_W-1:0] scale;
		logic [BASE_W-1:0]  base;
	} ctrl_cfg_t;

	typedef struct packed {
		logic moving;
		logic forward;
	} step_dir_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0]  count;
		logic signed [VEL_W-1:0] velocity;
		step_dir_t               dir;
		logic [PER_W-1:0]        period;
	} ctrl_upd_t;

endpackage

/* hw/rtl/sdsv_in_if.sv */
// Input channel of the servo: timer tick or ADC completion request.
// Depends on sdsv_pkg.
interface sdsv_in_if;
	import sdsv_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output mode, output adc_sample, input ready);
	modport sink   (input valid, input mode, input adc_sample, output ready);
endinterface

/* hw/rtl/sdsv_out_if.sv */
// Result channel of the servo: step pulse, direction, velocity, period.
// Depends on sdsv_pkg.
interface sdsv_out_if;
	import sdsv_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    step_pulse;
	logic                    direction_level;
	logic signed [VEL_W-1:0] velocity;
	logic [PER_W-1:0]        step_period;

	modport source (output valid, output step_pulse, output direction_level,
		output velocity, output step_period, input ready);
	modport sink   (input valid, input step_pulse, input direction_level,
		input velocity, input step_period, output ready);
endinterface

/* hw/rtl/step_dir_servo_velocity_loop.sv */
// Step/direction servo with a ramped velocity loop, top level.
// Depends on sdsv_pkg, sdsv_in_if, sdsv_out_if and sdsv_update.
//
// Usage:
//  - items (valid/ready): mode 0 is one prescaled timer tick, mode 1 is an
//    ADC completion carrying adc_sample. Every request yields one result.
//  - results (valid/ready): step_pulse, direction_level, velocity and
//    step_period as they stand after the request has been applied.
//  - cfg_we/cfg_index/cfg_data: register writes (velocity limit, rate scale,
//    rate base, samples per update), taken on any edge with cfg_we high;
//    write only while no request is in flight.
// Throughput: one request per cycle while results are taken. A request is
// captured in the input register, processed from there, and its result is
// held in the result register.
// All servo state is read and written by the combinational update between
// these two registers, so back-to-back requests see each other's effects.
// Reset: all state to its start values, registers to their defaults, no
// result pending. A stalled receiver holds the result register; the input
// register then keeps its request and items.ready drops until results move.
module step_dir_servo_velocity_loop (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sdsv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdsv_pkg::CFG_DATA_W-1:0] cfg_data,
	sdsv_in_if.sink                         items,
	sdsv_out_if.source                      results
);
	import sdsv_pkg::*;

	// configuration
	ctrl_cfg_t        cfg_q;
	logic [SPU_W-1:0] spu_q;

	// input stage
	logic                valid_s1;
	logic                mode_s1;
	logic [ADC_BITS-1:0] adc_s1;

	// servo state
	logic [SMP_W-1:0]        smp_q;
	logic [COUNT_WIDTH-1:0]  cnt_q;
	logic signed [VEL_W-1:0] vel_q;
	step_dir_t               dir_q;
	logic [PER_W-1:0]        next_per_q;
	logic [PER_W-1:0]        active_per_q;
	logic [TICK_W-1:0]       tick_q;
	logic [SPU_W-1:0]        left_q;
	logic                    started_q;
	logic                    pin_q;

	// next state
	logic [SMP_W-1:0]        smp_new;
	logic [SMP_W-1:0]        n_smp;
	logic [COUNT_WIDTH-1:0]  n_cnt;
	logic signed [VEL_W-1:0] n_vel;
	step_dir_t               n_dir;
	logic [PER_W-1:0]        n_next_per;
	logic [PER_W-1:0]        n_active_per;
	logic [TICK_W-1:0]       n_tick;
	logic [SPU_W-1:0]        n_left;
	logic                    n_started;
	logic                    n_pin;
	logic                    n_pulse;

	// result register
	logic                    res_valid_q;
	logic                    pulse_q;
	logic                    dir_lvl_q;
	logic signed [VEL_W-1:0] res_vel_q;
	logic [PER_W-1:0]        res_per_q;

	logic      adv;
	logic      fire;
	ctrl_upd_t upd;

	assign adv         = !res_valid_q || results.ready;
	assign fire        = valid_s1 && adv;
	assign items.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit <= LIMIT_RST;
			cfg_q.scale <= SCALE_RST;
			cfg_q.base  <= BASE_RST;
			spu_q       <= SPU_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VEL_LIMIT:  cfg_q.limit <= LIM_W'(cfg_data);
				REG_RATE_SCALE: cfg_q.scale <= SCALE_W'(cfg_data);
				REG_RATE_BASE:  cfg_q.base  <= BASE_W'(cfg_data);
				REG_SAMPLES:    spu_q       <= SPU_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			mode_s1 <= items.mode;
			adc_s1  <= items.adc_sample;
		end
	end

	assign smp_new = SMP_W'(adc_s1) + SMP_W'(SAMPLE_OFFSET);

	sdsv_update u_update (
		.count    (cnt_q),
		.started  (started_q),
		.sample   (smp_new),
		.velocity (vel_q),
		.period   (next_per_q),
		.cfg      (cfg_q),
		.upd      (upd)
	);

	always_comb begin
		n_smp        = smp_q;
		n_cnt        = cnt_q;
		n_vel        = vel_q;
		n_dir        = dir_q;
		n_next_per   = next_per_q;
		n_active_per = active_per_q;
		n_tick       = tick_q;
		n_left       = left_q;
		n_started    = started_q;
		n_pin        = pin_q;
		n_pulse      = 1'b0;
		if (mode_s1) begin
			n_smp = smp_new;
			if (left_q > SPU_W'(1)) begin
				n_left = left_q - SPU_W'(1);
			end else begin
				n_cnt      = upd.count;
				n_vel      = upd.velocity;
				n_dir      = upd.dir;
				n_next_per = upd.period;
				n_started  = 1'b1;
				n_left     = spu_q;
			end
		end else if (tick_q == TICK_W'(active_per_q)) begin
			n_tick       = '0;
			n_active_per = next_per_q;
			if (dir_q.moving) begin
				n_pulse = 1'b1;
				n_pin   = dir_q.forward;
				// forward steps count the position down
				n_cnt   = dir_q.forward ? cnt_q - COUNT_WIDTH'(1) : cnt_q + COUNT_WIDTH'(1);
			end
		end else begin
			n_tick = tick_q + TICK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q        <= '0;
			cnt_q        <= '0;
			vel_q        <= '0;
			dir_q        <= '0;
			next_per_q   <= PERIOD_RST;
			active_per_q <= PERIOD_RST;
			tick_q       <= '0;
			left_q       <= SPU_RST;
			started_q    <= 1'b0;
			pin_q        <= 1'b0;
		end else if (fire) begin
			smp_q        <= n_smp;
			cnt_q        <= n_cnt;
			vel_q        <= n_vel;
			dir_q        <= n_dir;
			next_per_q   <= n_next_per;
			active_per_q <= n_active_per;
			tick_q       <= n_tick;
			left_q       <= n_left;
			started_q    <= n_started;
			pin_q        <= n_pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pulse_q   <= n_pulse;
			dir_lvl_q <= n_pin;
			res_vel_q <= n_vel;
			res_per_q <= n_active_per;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.step_pulse      = pulse_q;
	assign results.direction_level = dir_lvl_q;
	assign results.velocity        = res_vel_q;
	assign results.step_period     = res_per_q;

	// ADC requests never step
	a_no_step_on_adc: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_s1) |=> !pulse_q)
		else $error("step pulse issued for an ADC request");

	// velocity ramps by at most one unit per request
	a_ramp_one: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (vel_q == $past(vel_q) || vel_q == $past(vel_q) + 9'sd1 ||
			vel_q == $past(vel_q) - 9'sd1))
		else $error("velocity moved by more than one unit");

	// direction is idle exactly when velocity is zero
	a_dir_matches_vel: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q.moving == (vel_q != '0))
		else $error("step direction out of step with velocity");

endmodule

/* hw/rtl/sdsv_update.sv */
// Control update of the servo: target, velocity ramp, direction and period.
// Purely combinational; depends on sdsv_pkg.
module sdsv_update (
	input  logic [sdsv_pkg::COUNT_WIDTH-1:0]  count,
	input  logic                              started,
	input  logic [sdsv_pkg::SMP_W-1:0]        sample,
	input  logic signed [sdsv_pkg::VEL_W-1:0] velocity,
	input  logic [sdsv_pkg::PER_W-1:0]        period,
	input  sdsv_pkg::ctrl_cfg_t               cfg,
	output sdsv_pkg::ctrl_upd_t               upd
);
	import sdsv_pkg::*;

	logic [COUNT_WIDTH-1:0]   cnt_eff;
	logic signed [DIFF_W-1:0] cnt_x;
	logic signed [DIFF_W-1:0] smp_x;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] half;
	logic signed [DIFF_W-1:0] lim_x;
	logic signed [DIFF_W-1:0] clamped;
	logic signed [VEL_W-1:0]  target;
	logic signed [VEL_W-1:0]  vel_new;
	logic signed [VEL_W-1:0]  vel_neg;
	logic [MAG_W-1:0]         mag;
	logic [PROD_W-1:0]        prod;
	logic [NUM_W-1:0]         num;
	logic [QUO_W-1:0]         quo;
	logic [PER_W-1:0]         per_new;

	always_comb begin
		// first update loads the counter from the sample
		cnt_eff = started ? count : COUNT_WIDTH'(DIFF_W'(sample));
		cnt_x   = DIFF_W'(signed'(cnt_eff));
		smp_x   = signed'(DIFF_W'(sample));
		diff    = cnt_x - smp_x;
		// divide by two, truncating toward zero
		half    = (diff + signed'(DIFF_W'(diff[DIFF_W-1]))) >>> 1;
		lim_x   = signed'(DIFF_W'(cfg.limit));
		if (half > lim_x) begin
			clamped = lim_x;
		end else if (half < -lim_x) begin
			clamped = -lim_x;
		end else begin
			clamped = half;
		end
		target = VEL_W'(clamped);

		if (target > velocity) begin
			vel_new = velocity + VEL_W'(1);
		end else if (target < velocity) begin
			vel_new = velocity - VEL_W'(1);
		end else begin
			vel_new = velocity;
		end

		vel_neg = -vel_new;
		mag     = vel_new[VEL_W-1] ? MAG_W'(vel_neg) : MAG_W'(vel_new);
		prod    = PROD_W'(cfg.scale) * PROD_W'(mag);
		num     = NUM_W'(cfg.base) - NUM_W'(prod);
		quo     = num[NUM_W-1] ? '0 : num[NUM_W-2:PERIOD_SHIFT];
		if (QUO_W'(quo) > QUO_W'(PERIOD_MAX)) begin
			per_new = PERIOD_MAX;
		end else begin
			per_new = PER_W'(quo);
		end

		upd.count       = cnt_eff;
		upd.velocity    = vel_new;
		upd.dir.moving  = (vel_new != '0);
		upd.dir.forward = (vel_new != '0) && !vel_new[VEL_W-1];
		// at rest the period is kept
		upd.period      = (vel_new != '0) ? per_new : period;
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for step_dir_servo_velocity_loop: predicts each result of the servo
// loop and compares it field by field. Depends on sdsv_pkg, sdsv_in_if and sdsv_out_if.
module tb_top;
	import sdsv_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 20;
	localparam bit MODE_TICK    = 1'b0;
	localparam bit MODE_ADC     = 1'b1;

	typedef struct {
		logic                    step_pulse;
		logic                    direction_level;
		logic signed [VEL_W-1:0] velocity;
		logic [PER_W-1:0]        step_period;
	} servo_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sdsv_in_if  items_if ();
	sdsv_out_if results_if ();

	step_dir_servo_velocity_loop DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items_if),
		.results   (results_if)
	);

	always #CLK_HALF clk = ~clk;

	// predictor state
	logic [LIM_W-1:0]       m_limit;
	logic [SCALE_W-1:0]     m_scale;
	logic [BASE_W-1:0]      m_base;
	logic [SPU_W-1:0]       m_spu;
	logic [SMP_W-1:0]       m_sample;
	logic [COUNT_WIDTH-1:0] m_count;
	int                     m_vel;
	int                     m_dir;
	logic [PER_W-1:0]       m_next_per;
	logic [PER_W-1:0]       m_act_per;
	logic [TICK_W-1:0]      m_tick;
	logic [SPU_W-1:0]       m_left;
	bit                     m_started;
	bit                     m_dir_pin;

	servo_out_t servo_outputs_due[$];
	bit         no_idle;
	int         failures;
	int         requests_sent;
	int         results_checked;
	int         steps_seen;
	int         settings_applied;
	int         cycle_count;

	function void reset_servo_model();
		m_limit    = LIMIT_RST;
		m_scale    = SCALE_RST;
		m_base     = BASE_RST;
		m_spu      = SPU_RST;
		m_sample   = '0;
		m_count    = '0;
		m_vel      = 0;
		m_dir      = 0;
		m_next_per = PERIOD_RST;
		m_act_per  = PERIOD_RST;
		m_tick     = '0;
		m_left     = SPU_RST;
		m_started  = 1'b0;
		m_dir_pin  = 1'b0;
	endfunction

	function void update_velocity();
		int cnt_s;
		int target;
		int lim;
		int mag;
		int num;
		if (!m_started) begin
			m_count   = COUNT_WIDTH'(m_sample);
			m_started = 1'b1;
		end
		cnt_s  = $signed(m_count);
		target = (cnt_s - int'(m_sample)) / 2;
		lim    = int'(m_limit);
		if (target > lim)
			target = lim;
		if (target < -lim)
			target = -lim;
		if (target > m_vel)
			m_vel++;
		else if (target < m_vel)
			m_vel--;
		if (m_vel == 0) begin
			m_dir = 0;
			return;
		end
		m_dir = (m_vel < 0) ? -1 : 1;
		mag   = (m_vel < 0) ? -m_vel : m_vel;
		num   = int'(m_base) - int'(m_scale) * mag;
		if (num < 0)
			num = 0;
		num = num / (1 << PERIOD_SHIFT);
		if (num > int'(PERIOD_MAX))
			num = int'(PERIOD_MAX);
		m_next_per = PER_W'(num);
	endfunction

	function servo_out_t predict_servo(bit mode, logic [ADC_BITS-1:0] raw);
		servo_out_t o;
		o.step_pulse = 1'b0;
		if (mode == MODE_ADC) begin
			m_sample = SMP_W'(raw) + SMP_W'(SAMPLE_OFFSET);
			if (m_left > 1) begin
				m_left--;
			end else begin
				update_velocity();
				m_left = m_spu;
			end
		end else if (m_tick == m_act_per) begin
			m_tick    = '0;
			m_act_per = m_next_per;
			if (m_dir != 0) begin
				o.step_pulse = 1'b1;
				m_dir_pin    = (m_dir > 0);
				if (m_dir > 0)
					m_count--;
				else
					m_count++;
			end
		end else begin
			m_tick++;
		end
		o.direction_level = m_dir_pin;
		o.velocity        = VEL_W'(m_vel);
		o.step_period     = m_act_per;
		return o;
	endfunction

	task automatic send_request(bit mode, logic [ADC_BITS-1:0] raw);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid      <= 1'b1;
		items_if.mode       <= mode;
		items_if.adc_sample <= raw;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		servo_outputs_due.push_back(predict_servo(mode, raw));
		requests_sent++;
	endtask

	task automatic settle();
		items_if.valid <= 1'b0;
		while (servo_outputs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic apply_settings(int lim, int scale, int base, int spu);
		cfg_reg_t              regs[4];
		logic [CFG_DATA_W-1:0] vals[4];
		regs[0] = REG_VEL_LIMIT;
		regs[1] = REG_RATE_SCALE;
		regs[2] = REG_RATE_BASE;
		regs[3] = REG_SAMPLES;
		vals[0] = CFG_DATA_W'(lim);
		vals[1] = CFG_DATA_W'(scale);
		vals[2] = CFG_DATA_W'(base);
		vals[3] = CFG_DATA_W'(spu);
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			case (regs[i])
				REG_VEL_LIMIT:  m_limit = LIM_W'(vals[i]);
				REG_RATE_SCALE: m_scale = SCALE_W'(vals[i]);
				REG_RATE_BASE:  m_base  = BASE_W'(vals[i]);
				REG_SAMPLES:    m_spu   = SPU_W'(vals[i]);
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// samples mostly follow a slowly moving setpoint so the counter has something to chase
	task automatic run_tracking(int count, int adc_pct);
		int                  setpoint;
		int                  level;
		bit                  mode;
		logic [ADC_BITS-1:0] raw;
		setpoint = $urandom_range((1 << ADC_BITS) - 1);
		repeat (count) begin
			if ($urandom_range(99) < 3)
				setpoint = $urandom_range((1 << ADC_BITS) - 1);
			mode = ($urandom_range(99) < adc_pct) ? MODE_ADC : MODE_TICK;
			if ($urandom_range(99) < 85) begin
				level = setpoint + int'($urandom_range(8)) - 4;
				if (level < 0)
					level = 0;
				if (level > (1 << ADC_BITS) - 1)
					level = (1 << ADC_BITS) - 1;
				raw = ADC_BITS'(level);
			end else begin
				raw = ADC_BITS'($urandom);
			end
			send_request(mode, raw);
		end
	endtask

	task automatic test_directed_corners();
		send_request(MODE_TICK, '0);
		send_request(MODE_TICK, '1);
		send_request(MODE_ADC, '0);
		send_request(MODE_ADC, '1);   // first update loads the counter
		send_request(MODE_ADC, '0);
		send_request(MODE_ADC, '0);
		send_request(MODE_TICK, '0);
		settle();
		apply_settings(0, 49, 16335, 2);   // zero limit pulls velocity back to rest
		send_request(MODE_ADC, '0);
		send_request(MODE_ADC, '0);
		send_request(MODE_TICK, '1);
		settle();
		apply_settings(255, 63, 0, 0);     // period numerator goes negative; zero rate
		send_request(MODE_ADC, '0);
		send_request(MODE_ADC, '0);
		send_request(MODE_ADC, '0);
		send_request(MODE_TICK, '0);
		settle();
		apply_settings(255, 0, 16383, 1);  // period lands on its maximum
		send_request(MODE_ADC, '0);
		send_request(MODE_ADC, '1);
		send_request(MODE_TICK, '1);
		settle();
	endtask

	task automatic test_back_to_back();
		apply_settings(255, 0, 300, 1);
		no_idle = 1'b1;
		run_tracking(120, 15);
		settle();
		no_idle = 1'b0;
	endtask

	task automatic test_tracking_sweep();
		apply_settings(255, 0, 120, 1);
		run_tracking(100, 20);
		settle();
		apply_settings(1, 63, 100, 0);
		run_tracking(50, 30);
		settle();
		apply_settings(0, 10, 2000, 3);
		run_tracking(50, 30);
		settle();
		apply_settings(40, 63, 16383, 2);
		run_tracking(50, 30);
		settle();
		apply_settings(255, 1, 640, 1);
		run_tracking(50, 25);
		settle();
	endtask

	task automatic test_slow_update_rate();
		apply_settings(255, 49, 16335, 40);
		run_tracking(80, 97);
		settle();
	endtask

	always @(posedge clk)
		results_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		servo_out_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (servo_outputs_due.size() == 0) begin
				$error("result with no request pending");
				failures++;
			end else begin
				want = servo_outputs_due.pop_front();
				results_checked++;
				if (results_if.step_pulse === 1'b1)
					steps_seen++;
				if (results_if.step_pulse !== want.step_pulse) begin
					$error("step_pulse: expected %0d, got %0d",
						want.step_pulse, results_if.step_pulse);
					failures++;
				end
				if (results_if.direction_level !== want.direction_level) begin
					$error("direction_level: expected %0d, got %0d",
						want.direction_level, results_if.direction_level);
					failures++;
				end
				if (results_if.velocity !== want.velocity) begin
					$error("velocity: expected %0d, got %0d",
						want.velocity, results_if.velocity);
					failures++;
				end
				if (results_if.step_period !== want.step_period) begin
					$error("step_period: expected %0d, got %0d",
						want.step_period, results_if.step_period);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_VEL_LIMIT;
		cfg_data            = '0;
		items_if.valid      = 1'b0;
		items_if.mode       = MODE_TICK;
		items_if.adc_sample = '0;
		no_idle             = 1'b0;
		reset_servo_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_back_to_back();
		test_tracking_sweep();
		test_slow_update_rate();
		settle();
		$display("Covered %0d requests over %0d register settings: %0d results checked,",
			requests_sent, settings_applied, results_checked);
		$display("  %0d step pulses seen, %0d mismatches.", steps_seen, failures);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
